// ----- rtl/core/fold_pkg.sv -----
// Shared types, constants and stencil coefficients for the fourth-order
// line derivative block. No dependencies.
package fold_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int DERIV_W          = 19;
    localparam int WIN_LEN          = 5;
    localparam int PLAN_LEN         = 5;
    localparam int CNT_W            = 3;
    localparam int SEEN_W           = 3;
    localparam int SEEN_FULL        = 5;    // window just filled
    localparam int SEEN_MAX         = 6;    // more than five samples seen
    localparam int COEF_W           = 8;
    localparam int TERM_GROW        = 7;    // |coef| <= 48
    localparam int SUM_GROW         = 8;    // sum of |coef| <= 128

    // divide by 24: round, shift right by 3, then multiply by a reciprocal of 3
    localparam int DIV_PRE    = 3;
    localparam int ROUND_ADD  = 12;
    localparam int MAG_LO_W   = 23;
    localparam int T_W        = 20;
    localparam int MUL_W      = 21;
    localparam int DIV3_SHIFT = 22;
    localparam int Q_W        = DERIV_W - 1;
    localparam logic [MUL_W-1:0] DIV3_MUL = MUL_W'(((1 << DIV3_SHIFT) + 2) / 3);
    // smallest magnitude whose rounded quotient no longer fits
    localparam int SAT_MAG = 24 * (1 << (DERIV_W - 1)) - ROUND_ADD;

    localparam logic [DERIV_W-1:0] DERIV_MAX = {1'b0, {Q_W{1'b1}}};
    localparam logic [DERIV_W-1:0] DERIV_MIN = {1'b1, {Q_W{1'b0}}};

    typedef enum logic [2:0] {
        K_FIRST    = 3'd0,
        K_SECOND   = 3'd1,
        K_CENTER   = 3'd2,
        K_NEAR_END = 3'd3,
        K_END      = 3'd4,
        K_SHORT    = 3'd5
    } kind_t;

    typedef struct packed {
        logic valid;
        logic point_is_last;
        logic run_last;
        logic short_line;
    } ctrl_t;

    typedef struct packed {
        ctrl_t ctrl;
        kind_t kind;
    } issue_t;

    // weight of window position pos (0 = oldest) for stencil k
    function automatic logic signed [COEF_W-1:0] coeff(kind_t k, logic [2:0] pos);
        logic signed [COEF_W-1:0] c;
        c = '0;
        case (k)
            K_FIRST:
            begin
                case (pos)
                    3'd0:    c = -8'sd25;
                    3'd1:    c =  8'sd48;
                    3'd2:    c = -8'sd36;
                    3'd3:    c =  8'sd16;
                    3'd4:    c = -8'sd3;
                    default: c = '0;
                endcase
            end
            K_SECOND:
            begin
                case (pos)
                    3'd0:    c = -8'sd3;
                    3'd1:    c = -8'sd10;
                    3'd2:    c =  8'sd18;
                    3'd3:    c = -8'sd6;
                    3'd4:    c =  8'sd1;
                    default: c = '0;
                endcase
            end
            K_CENTER:
            begin
                case (pos)
                    3'd0:    c =  8'sd1;
                    3'd1:    c = -8'sd8;
                    3'd3:    c =  8'sd8;
                    3'd4:    c = -8'sd1;
                    default: c = '0;
                endcase
            end
            K_NEAR_END:
            begin
                case (pos)
                    3'd0:    c = -8'sd1;
                    3'd1:    c =  8'sd6;
                    3'd2:    c = -8'sd18;
                    3'd3:    c =  8'sd10;
                    3'd4:    c =  8'sd3;
                    default: c = '0;
                endcase
            end
            K_END:
            begin
                case (pos)
                    3'd0:    c =  8'sd3;
                    3'd1:    c = -8'sd16;
                    3'd2:    c =  8'sd36;
                    3'd3:    c = -8'sd48;
                    3'd4:    c =  8'sd25;
                    default: c = '0;
                endcase
            end
            default: c = '0;   // short line: all weights zero
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/fourth_order_line_derivative.sv -----
// Top level of the fourth-order line derivative: window cells, result
// sequencer, stencil sum and divide pipeline. Uses fold_pkg and all modules.
//
// Samples of one line arrive in order, the last one flagged by line_end; each
// sample is one item. The block returns the fourth-order first derivative of
// every point of the line (stencil sum / 24, rounded to nearest with ties away
// from zero, clamped to 19 bits): centered stencils inside, one-sided five-
// point stencils for the first two and last two points. The first four
// samples of a line give no result, the fifth gives three, each later one
// gives one, and the flagged last sample adds two more (a line of exactly five
// samples gives all five at its end). A line under five samples gives a
// single result with short_line set and derivative zero. run_last marks the
// final result of each input item. Rate: while the output is not stalled, the
// sequencer issues one stencil per cycle into the arithmetic pipe, so an item
// that causes several results holds off the next one until its last stencil
// issues; in the body of a long line that is one item per clock. An accepted
// item passes the registered stages stencil terms, sum, round, divide by 3
// and clamp. A stalled output freezes the whole pipe.
module fourth_order_line_derivative #(
    parameter int SAMPLE_WIDTH = fold_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]      sample,
    input  logic                                line_end,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [fold_pkg::DERIV_W-1:0] derivative,
    output logic                                point_is_last,
    output logic                                run_last,
    output logic                                short_line
);

    localparam int WL     = fold_pkg::WIN_LEN;
    localparam int TERM_W = SAMPLE_WIDTH + fold_pkg::TERM_GROW;
    localparam int SUM_W  = SAMPLE_WIDTH + fold_pkg::SUM_GROW;

    logic                     accept;
    logic                     ready;
    logic                     adv;
    fold_pkg::issue_t         issue;
    fold_pkg::ctrl_t          c1_reg, c2_reg, out_ctrl;

    // window: index 0 holds the oldest sample
    logic signed [SAMPLE_WIDTH-1:0] win [WL];
    logic signed [SAMPLE_WIDTH-1:0] chain_in [WL];
    logic signed [TERM_W-1:0]       terms [WL];
    logic signed [SUM_W-1:0]        sum_reg, sum_next;

    // the whole pipe moves whenever the output register is free or taken
    assign adv      = !out_ctrl.valid || !out_stall;
    assign in_stall = !ready;
    assign accept   = in_valid && ready;

    fold_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .line_end (line_end),
        .adv      (adv),
        .ready    (ready),
        .issue    (issue)
    );

    // row of cells; new samples enter at the newest end and move one step
    // toward the oldest end on every accepted item
    for (genvar i = 0; i < WL; i++)
    begin : g_cell
        if (i == WL - 1)
        begin : g_head
            assign chain_in[i] = sample;
        end
        else
        begin : g_link
            assign chain_in[i] = win[i+1];
        end

        fold_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .POS          (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (accept),
            .adv        (adv),
            .kind       (issue.kind),
            .sample_in  (chain_in[i]),
            .sample_out (win[i]),
            .term       (terms[i])
        );
    end

    // five-term stencil sum
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < WL; i++)
        begin
            sum_next = sum_next + SUM_W'(terms[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
        end
        else if (adv)
        begin
            c1_reg <= issue.ctrl;
            c2_reg <= c1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg <= sum_next;
        end
    end

    fold_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_ctrl    (c2_reg),
        .sum        (sum_reg),
        .out_ctrl   (out_ctrl),
        .derivative (derivative)
    );

    assign out_valid     = out_ctrl.valid;
    assign point_is_last = out_ctrl.point_is_last;
    assign run_last      = out_ctrl.run_last;
    assign short_line    = out_ctrl.short_line;

    // short-line marker: all weights zero, so the sum must be zero
    a_short_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        c2_reg.valid && c2_reg.short_line |-> sum_reg == '0)
        else $error("short-line item carries a nonzero stencil sum");

    a_short_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && short_line |-> point_is_last && run_last && derivative == '0)
        else $error("short-line result malformed");

    a_last_point_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_is_last |-> run_last)
        else $error("final point of a line is not the last result of its item");

endmodule

// ----- rtl/core/fold_cell.sv -----
// One window cell: holds a sample, passes it to the older neighbor, and
// registers its weighted term for the stencil being issued. Uses fold_pkg.
module fold_cell #(
    parameter int SAMPLE_WIDTH = fold_pkg::SAMPLE_WIDTH_DEF,
    parameter int POS          = 0
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  shift_en,
    input  logic                                  adv,
    input  fold_pkg::kind_t                       kind,
    input  logic signed [SAMPLE_WIDTH-1:0]        sample_in,
    output logic signed [SAMPLE_WIDTH-1:0]        sample_out,
    output logic signed [SAMPLE_WIDTH+fold_pkg::TERM_GROW-1:0] term
);

    localparam int TERM_W = SAMPLE_WIDTH + fold_pkg::TERM_GROW;

    logic signed [SAMPLE_WIDTH-1:0]       sample_reg;
    logic signed [TERM_W-1:0]             term_reg;
    logic signed [TERM_W-1:0]             term_next;
    logic signed [TERM_W-1:0]             sx;
    logic signed [TERM_W-1:0]             cx;

    assign sx        = TERM_W'(sample_reg);
    assign cx        = TERM_W'(fold_pkg::coeff(kind, 3'(POS)));
    assign term_next = sx * cx;

    // window starts all zero so zero-weight stencils give a clean zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            term_reg   <= '0;
        end
        else
        begin
            if (shift_en)
            begin
                sample_reg <= sample_in;
            end
            if (adv)
            begin
                term_reg <= term_next;
            end
        end
    end

    assign sample_out = sample_reg;
    assign term       = term_reg;

endmodule

// ----- rtl/core/fold_seq.sv -----
// Result sequencer: tracks samples seen in the line and queues the stencils
// each item calls for, issuing one per cycle while the pipe advances. Uses fold_pkg.
module fold_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             line_end,
    input  logic             adv,
    output logic             ready,
    output fold_pkg::issue_t issue
);

    localparam int PL = fold_pkg::PLAN_LEN;
    localparam int CW = fold_pkg::CNT_W;
    localparam int SW = fold_pkg::SEEN_W;

    logic [SW-1:0]    seen_reg, seen_next, seen_inc;
    logic [CW-1:0]    cnt_reg, cnt_next, plan_cnt;
    fold_pkg::kind_t  kinds_reg [PL];
    fold_pkg::kind_t  kinds_next [PL];
    fold_pkg::kind_t  plan [PL];
    logic             pop;

    assign seen_inc = (seen_reg == SW'(fold_pkg::SEEN_MAX)) ? seen_reg : seen_reg + SW'(1);

    always_comb
    begin
        for (int i = 0; i < PL; i++)
        begin
            plan[i] = fold_pkg::K_CENTER;
        end
        plan_cnt = '0;
        if (seen_inc < SW'(fold_pkg::SEEN_FULL))
        begin
            if (line_end)
            begin
                plan[0]  = fold_pkg::K_SHORT;
                plan_cnt = CW'(1);
            end
        end
        else if (seen_inc == SW'(fold_pkg::SEEN_FULL))
        begin
            plan[0]  = fold_pkg::K_FIRST;
            plan[1]  = fold_pkg::K_SECOND;
            plan[2]  = fold_pkg::K_CENTER;
            plan_cnt = CW'(3);
            if (line_end)
            begin
                plan[3]  = fold_pkg::K_NEAR_END;
                plan[4]  = fold_pkg::K_END;
                plan_cnt = CW'(PL);
            end
        end
        else
        begin
            plan[0]  = fold_pkg::K_CENTER;
            plan_cnt = CW'(1);
            if (line_end)
            begin
                plan[1]  = fold_pkg::K_NEAR_END;
                plan[2]  = fold_pkg::K_END;
                plan_cnt = CW'(3);
            end
        end
    end

    assign pop   = adv && (cnt_reg != '0);
    assign ready = (cnt_reg == '0) || ((cnt_reg == CW'(1)) && adv);

    always_comb
    begin
        seen_next = seen_reg;
        cnt_next  = cnt_reg;
        for (int i = 0; i < PL; i++)
        begin
            kinds_next[i] = kinds_reg[i];
        end
        if (accept)
        begin
            seen_next = line_end ? '0 : seen_inc;
            cnt_next  = plan_cnt;
            for (int i = 0; i < PL; i++)
            begin
                kinds_next[i] = plan[i];
            end
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - CW'(1);
            for (int i = 0; i < PL - 1; i++)
            begin
                kinds_next[i] = kinds_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            cnt_reg  <= '0;
            for (int i = 0; i < PL; i++)
            begin
                kinds_reg[i] <= fold_pkg::K_CENTER;
            end
        end
        else
        begin
            seen_reg <= seen_next;
            cnt_reg  <= cnt_next;
            for (int i = 0; i < PL; i++)
            begin
                kinds_reg[i] <= kinds_next[i];
            end
        end
    end

    always_comb
    begin
        issue.kind               = kinds_reg[0];
        issue.ctrl.valid         = (cnt_reg != '0);
        issue.ctrl.run_last      = (cnt_reg == CW'(1));
        issue.ctrl.point_is_last = (kinds_reg[0] == fold_pkg::K_END) ||
                                   (kinds_reg[0] == fold_pkg::K_SHORT);
        issue.ctrl.short_line    = (kinds_reg[0] == fold_pkg::K_SHORT);
    end

endmodule

// ----- rtl/core/fold_div.sv -----
// Rounded divide by 24 with saturation, three stages ending in the output
// register. Uses fold_pkg.
module fold_div #(
    parameter int SUM_W = fold_pkg::SAMPLE_WIDTH_DEF + fold_pkg::SUM_GROW
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  fold_pkg::ctrl_t                     in_ctrl,
    input  logic signed [SUM_W-1:0]             sum,
    output fold_pkg::ctrl_t                     out_ctrl,
    output logic signed [fold_pkg::DERIV_W-1:0] derivative
);

    localparam int MW = (SUM_W > fold_pkg::MAG_LO_W + 1) ? SUM_W : fold_pkg::MAG_LO_W + 1;
    localparam int RW = fold_pkg::MAG_LO_W + 1;
    localparam int PW = fold_pkg::T_W + fold_pkg::MUL_W;

    fold_pkg::ctrl_t              ca_reg, cb_reg, cc_reg;
    logic                         neg_a_reg, sat_a_reg, neg_b_reg, sat_b_reg;
    logic [fold_pkg::T_W-1:0]     t_a_reg;
    logic [fold_pkg::Q_W-1:0]     q_b_reg;
    logic [fold_pkg::DERIV_W-1:0] deriv_reg, deriv_next;

    logic                         neg;
    logic [SUM_W-1:0]             mag;
    logic [MW-1:0]                mag_ext;
    logic [RW-1:0]                rnd;
    logic [PW-1:0]                prod;
    logic [fold_pkg::DERIV_W-1:0] q_ext;

    // stage A: magnitude, overflow check, round and drop the factor of 8
    assign neg     = sum[SUM_W-1];
    assign mag     = neg ? SUM_W'(-sum) : SUM_W'(sum);
    assign mag_ext = MW'(mag);
    assign rnd     = {1'b0, mag_ext[fold_pkg::MAG_LO_W-1:0]} + RW'(fold_pkg::ROUND_ADD);

    // stage B: divide by 3 through the reciprocal
    assign prod = PW'(t_a_reg) * PW'(fold_pkg::DIV3_MUL);

    // stage C: sign and clamp
    assign q_ext = {1'b0, q_b_reg};
    always_comb
    begin
        if (sat_b_reg)
        begin
            deriv_next = neg_b_reg ? fold_pkg::DERIV_MIN : fold_pkg::DERIV_MAX;
        end
        else
        begin
            deriv_next = neg_b_reg ? -q_ext : q_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ca_reg <= '0;
            cb_reg <= '0;
            cc_reg <= '0;
        end
        else if (adv)
        begin
            ca_reg <= in_ctrl;
            cb_reg <= ca_reg;
            cc_reg <= cb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_a_reg <= neg;
            sat_a_reg <= (mag_ext >= MW'(fold_pkg::SAT_MAG));
            t_a_reg   <= rnd[fold_pkg::DIV_PRE +: fold_pkg::T_W];
            neg_b_reg <= neg_a_reg;
            sat_b_reg <= sat_a_reg;
            q_b_reg   <= prod[fold_pkg::DIV3_SHIFT +: fold_pkg::Q_W];
            deriv_reg <= deriv_next;
        end
    end

    assign out_ctrl   = cc_reg;
    assign derivative = deriv_reg;

endmodule

// ----- tb/sv/fourth_order_line_derivative_tb.sv -----
// Self-checking testbench for fourth_order_line_derivative: streams sample lines
// in, predicts every derivative point, and checks the results in order.
// Depends on fold_pkg and the fourth_order_line_derivative RTL.
module fourth_order_line_derivative_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW         = fold_pkg::SAMPLE_WIDTH_DEF;
    localparam int DERIV_W    = fold_pkg::DERIV_W;
    localparam int CYCLE_LIMIT = 200000;   // far above the slowest legal run
    localparam int TAIL_CYCLES = 20;       // pipe is about five deep
    localparam int HOLD_START  = 150;      // receiver hold-off window, in rx cycles
    localparam int HOLD_STOP   = 270;
    localparam int RANDOM_ITEMS = 250;

    // one stimulus item: a sample and its end-of-line flag
    typedef struct packed {
        logic signed [SW-1:0] value;
        logic                 last;
    } sample_item_t;

    // one expected derivative point
    typedef struct packed {
        logic signed [DERIV_W-1:0] deriv;
        logic                      last_pt;
        logic                      run_end;
        logic                      short_ln;
    } deriv_point_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // DUT inputs start at known values
    logic                  in_valid  = 1'b0;
    logic signed [SW-1:0]  sample    = '0;
    logic                  line_end  = 1'b0;
    logic                  out_stall = 1'b0;

    logic                      in_stall;
    logic                      out_valid;
    logic signed [DERIV_W-1:0] derivative;
    logic                      point_is_last;
    logic                      run_last;
    logic                      short_line;

    sample_item_t sample_queue[$];      // items not yet offered
    deriv_point_t expected_points[$];   // predicted results, oldest first

    // predictor state: sliding window (newest at index 4) and line position
    logic signed [SW-1:0] win_hist [5];
    int unsigned          seen_in_line;

    logic in_taken   = 1'b0;   // item accepted at the last rising edge
    int   burst_left = 0;
    int   gap_left   = 0;
    int   rx_cycle   = 0;
    int   cycle_count = 0;

    int error_count  = 0;
    int items_sent   = 0;
    int points_ok    = 0;
    int lines_total  = 0;
    int short_total  = 0;

    fourth_order_line_derivative uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .line_end      (line_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .derivative    (derivative),
        .point_is_last (point_is_last),
        .run_last      (run_last),
        .short_line    (short_line)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // stencil sum / 24, nearest with ties away from zero, clamped to 19 bits
    function automatic logic signed [DERIV_W-1:0] round_div24(longint s);
        longint mag;
        longint q;
        mag = (s < 0) ? -s : s;
        q   = (mag + 12) / 24;
        if (s < 0)
            q = -q;
        if (q > longint'((1 << (DERIV_W - 1)) - 1))
            q = (1 << (DERIV_W - 1)) - 1;
        if (q < -longint'(1 << (DERIV_W - 1)))
            q = -longint'(1 << (DERIV_W - 1));
        return q[DERIV_W-1:0];
    endfunction

    function automatic deriv_point_t make_point(longint s, logic last_pt, logic short_ln);
        deriv_point_t p;
        p.deriv    = round_div24(s);
        p.last_pt  = last_pt;
        p.run_end  = 1'b0;
        p.short_ln = short_ln;
        return p;
    endfunction

    // Shift one sample into the line window and queue the derivative points
    // it releases. A line of five or more samples gets its two leading
    // one-sided points when the fifth sample lands, a centered point for each
    // sample from then on, and its two trailing one-sided points on line_end.
    task automatic compute_line_derivatives(input logic signed [SW-1:0] x, input logic le);
        longint       w [5];
        deriv_point_t burst[$];
        deriv_point_t p;
        for (int i = 0; i < 4; i++)
            win_hist[i] = win_hist[i+1];
        win_hist[4] = x;
        if (seen_in_line < 6)
            seen_in_line++;
        for (int i = 0; i < 5; i++)
            w[i] = longint'(win_hist[i]);

        if (seen_in_line < 5)
        begin
            // short line: a single flagged zero result
            if (le)
                burst.push_back(make_point(0, 1'b1, 1'b1));
        end
        else
        begin
            if (seen_in_line == 5)
            begin
                burst.push_back(make_point(-25*w[0] + 48*w[1] - 36*w[2] + 16*w[3] - 3*w[4],
                                           1'b0, 1'b0));
                burst.push_back(make_point(-3*w[0] - 10*w[1] + 18*w[2] - 6*w[3] + w[4],
                                           1'b0, 1'b0));
            end
            burst.push_back(make_point(w[0] - 8*w[1] + 8*w[3] - w[4], 1'b0, 1'b0));
            if (le)
            begin
                burst.push_back(make_point(3*w[4] + 10*w[3] - 18*w[2] + 6*w[1] - w[0],
                                           1'b0, 1'b0));
                burst.push_back(make_point(25*w[4] - 48*w[3] + 36*w[2] - 16*w[1] + 3*w[0],
                                           1'b1, 1'b0));
            end
        end

        if (burst.size() != 0)
        begin
            p = burst.pop_back();
            p.run_end = 1'b1;
            burst.push_back(p);
        end
        foreach (burst[i])
            expected_points.push_back(burst[i]);
        if (le)
            seen_in_line = 0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_sample(input int v, input logic le);
        sample_item_t it;
        it.value = SW'(v);
        it.last  = le;
        sample_queue.push_back(it);
    endtask

    // random sample: mostly full-range, some near zero (rounding ties), some rails
    function automatic int pick_sample();
        int k;
        k = $urandom_range(0, 7);
        if (k <= 3)
            return int'($signed(16'($urandom)));
        else if (k <= 5)
            return int'($urandom_range(0, 48)) - 24;
        else if (k == 6)
            return 32767;
        else
            return -32768;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued items in bursts, holds payload until taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_items
        sample_item_t nxt;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (sample_queue.size() != 0)
            begin
                nxt = sample_queue.pop_front();
                sample   <= nxt.value;
                line_end <= nxt.last;
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    // end of burst: pick the next burst length and the gap before it
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern steps through free running, light, heavy and periodic;
    // one long hold-off lets the pipe fill so the input side must stall.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_stall
        if (rst_n)
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_STOP)
                out_stall <= 1'b1;
            else
            begin
                case ((rx_cycle / 64) % 4)
                    0:       out_stall <= 1'b0;                          // free running
                    1:       out_stall <= ($urandom_range(0, 3) == 0);   // light
                    2:       out_stall <= ($urandom_range(0, 9) < 7);    // heavy
                    default: out_stall <= ((rx_cycle % 3) == 0);         // periodic
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Rising edge: record accepted items into the predictor, check results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : predict_and_check
        deriv_point_t want;
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                items_sent++;
                compute_line_derivatives(sample, line_end);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    $display("%0t: result with nothing expected: derivative=%0d last=%b",
                             $time, derivative, point_is_last);
                    $display("%0t:   run_last=%b short=%b", $time, run_last, short_line);
                    error_count++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (derivative !== want.deriv)
                    begin
                        $display("%0t: derivative expected %0d actual %0d",
                                 $time, want.deriv, derivative);
                        error_count++;
                    end
                    if (point_is_last !== want.last_pt)
                    begin
                        $display("%0t: point_is_last expected %b actual %b",
                                 $time, want.last_pt, point_is_last);
                        error_count++;
                    end
                    if (run_last !== want.run_end)
                    begin
                        $display("%0t: run_last expected %b actual %b",
                                 $time, want.run_end, run_last);
                        error_count++;
                    end
                    if (short_line !== want.short_ln)
                    begin
                        $display("%0t: short_line expected %b actual %b",
                                 $time, want.short_ln, short_line);
                        error_count++;
                    end
                    if (want.short_ln)
                        short_total++;
                    points_ok++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d items pending, %0d results outstanding",
                     $time, sample_queue.size(), expected_points.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : main_flow
        int random_count;
        int len;
        int r;
        for (int i = 0; i < 5; i++)
            win_hist[i] = '0;
        seen_in_line = 0;

        // directed: one-sample line at the positive rail
        queue_sample(32767, 1'b1);
        // four-sample line (still short) hitting both rails
        queue_sample(-32768, 1'b0);
        queue_sample(32767, 1'b0);
        queue_sample(0, 1'b0);
        queue_sample(-1, 1'b1);
        // exactly five samples, alternating rails: all five points at line end
        // with the largest stencil sums
        queue_sample(32767, 1'b0);
        queue_sample(-32768, 1'b0);
        queue_sample(32767, 1'b0);
        queue_sample(-32768, 1'b0);
        queue_sample(32767, 1'b1);
        // six samples with sums landing exactly on +/- half steps (ties)
        queue_sample(12, 1'b0);
        queue_sample(0, 1'b0);
        queue_sample(0, 1'b0);
        queue_sample(0, 1'b0);
        queue_sample(0, 1'b0);
        queue_sample(-12, 1'b1);
        // eight samples, rail pairs: centered points plus both one-sided ends
        queue_sample(-32768, 1'b0);
        queue_sample(-32768, 1'b0);
        queue_sample(32767, 1'b0);
        queue_sample(32767, 1'b0);
        queue_sample(-32768, 1'b0);
        queue_sample(-32768, 1'b0);
        queue_sample(32767, 1'b0);
        queue_sample(-32768, 1'b1);
        lines_total = 5;

        // random lines: mostly normal length, some short, some long
        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                len = $urandom_range(1, 4);
            else if (r == 1)
                len = $urandom_range(25, 40);
            else
                len = $urandom_range(5, 15);
            for (int i = 0; i < len; i++)
                queue_sample(pick_sample(), (i == len - 1));
            random_count += len;
            lines_total++;
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // all items taken, then all results back, then let the pipe settle
        while (sample_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d samples over %0d lines, %0d derivative points checked",
                 items_sent, lines_total, points_ok);
        $display("(%0d short-line results), receiver held off for %0d cycles once",
                 short_total, HOLD_STOP - HOLD_START);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
